[design/encoder_fault_monitor_top_assert.svh]
// Assertion macros used by the encoder fault monitor top level.
`ifndef ENCODER_FAULT_MONITOR_TOP_ASSERT_SVH
`define ENCODER_FAULT_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define EFM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define EFM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/efm_pkg.sv]
// Types and constants of the encoder fault monitor.
package efm_pkg;

    localparam int DRIVE_W  = 8;
    localparam int COUNT_W  = 8;
    localparam int THRESH_W = 7;
    localparam int MASK_W   = 8;
    localparam int LOOP_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd30;
    localparam logic [MASK_W-1:0]   MASK_RESET   = 8'h03;
    localparam logic [COUNT_W-1:0]  FAULT_MAX    = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_MASK      = 1'b1;

    // Per-tick control shared by both wheel lanes.
    typedef struct packed {
        logic                accept;
        logic                disabled;
        logic                clear;
        logic                decay;
        logic [THRESH_W-1:0] threshold;
    } tick_ctl_t;

    typedef struct packed {
        logic [COUNT_W-1:0] left_count;
        logic [COUNT_W-1:0] right_count;
    } result_t;

endpackage

[design/efm_if.sv]
// Valid/ready channel interfaces for ticks and fault-count results.
interface efm_tick_if import efm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                      left_pulses_seen;
    logic                      left_dir_reverse;
    logic                      right_pulses_seen;
    logic                      right_dir_reverse;
    logic                      robot_disabled;
    logic                      first_enabled_tick;
    logic [LOOP_W-1:0]         loop_count;

    modport source (
        output valid, left_drive, right_drive, left_pulses_seen, left_dir_reverse,
               right_pulses_seen, right_dir_reverse, robot_disabled,
               first_enabled_tick, loop_count,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, left_pulses_seen, left_dir_reverse,
               right_pulses_seen, right_dir_reverse, robot_disabled,
               first_enabled_tick, loop_count,
        output ready
    );
endinterface

interface efm_result_if import efm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] left_fault_count;
    logic [COUNT_W-1:0] right_fault_count;

    modport source (
        output valid, left_fault_count, right_fault_count,
        input  ready
    );
    modport sink (
        input  valid, left_fault_count, right_fault_count,
        output ready
    );
endinterface

[design/efm_lane.sv]
// One wheel lane: fault detection and the saturating fault counter.
module efm_lane import efm_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tick_ctl_t                 ctl,
    input  logic signed [DRIVE_W-1:0] drive,
    input  logic                      pulses_seen,
    input  logic                      dir_reverse,
    output logic [COUNT_W-1:0]        count,
    output logic [COUNT_W-1:0]        count_next
);

    logic [COUNT_W-1:0] count_reg;
    logic               reverse;
    logic [DRIVE_W-1:0] magnitude;
    logic               fault;
    logic [COUNT_W-1:0] risen;

    // Magnitude of the most negative drive wraps to 128, still correct unsigned.
    assign reverse   = drive[DRIVE_W-1];
    assign magnitude = reverse ? DRIVE_W'(-drive) : DRIVE_W'(drive);
    assign fault     = (magnitude > {{(DRIVE_W-THRESH_W){1'b0}}, ctl.threshold})
                    && (!pulses_seen || (reverse != dir_reverse));

    always_comb
    begin
        risen = (fault && (count_reg != FAULT_MAX)) ? count_reg + 1'b1 : count_reg;
        priority if (ctl.disabled)
        begin
            count_next = count_reg;
        end
        else if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.decay && (risen != '0))
        begin
            count_next = risen - 1'b1;
        end
        else
        begin
            count_next = risen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.accept)
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

[design/efm_merge.sv]
// Merge stage: joins both lane counts into one result, output register plus skid.
module efm_merge import efm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  result_t   data,
    output logic      push_ready,
    output logic      res_valid,
    input  logic      res_ready,
    output result_t   res_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    slot_free;

    assign slot_free  = !out_valid_reg || res_ready;
    assign push_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            // Drain the skid first; a push cannot happen while it is full.
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : data;
        end
        else if (push)
        begin
            skid_data_reg <= data;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

[design/encoder_fault_monitor_top.sv]
// Encoder fault monitor top level: two wheel lanes, config registers, result merge.
// A transferred tick's result is registered in the output register, or in the skid while
// that register holds an untaken result. Throughput: one tick per cycle while the skid
// is empty; the lanes update their counters in the accept cycle.
// A two-entry output stage (register plus skid) keeps ticks flowing while a result waits.
// Reset (rst_n, async, active low): counters cleared, threshold 30, decay mask 3, no result.
`include "encoder_fault_monitor_top_assert.svh"

module encoder_fault_monitor_top import efm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    efm_tick_if.sink              tick,
    efm_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [THRESH_W-1:0] thresh_reg;
    logic [MASK_W-1:0]   mask_reg;
    tick_ctl_t           ctl;
    logic                accept;
    logic                push_ready;
    logic [COUNT_W-1:0]  left_count;
    logic [COUNT_W-1:0]  right_count;
    result_t             lane_result;
    result_t             out_data;

    // Configuration writes: each index maps to one register, truncate to its width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            mask_reg   <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SPEED_THRESHOLD: thresh_reg <= cfg_wdata[THRESH_W-1:0];
                CFG_DECAY_MASK:      mask_reg   <= cfg_wdata[MASK_W-1:0];
                default:             ;
            endcase
        end
    end

    // A tick is taken whenever the skid slot is empty, even if a result is waiting.
    assign tick.ready = push_ready;
    assign accept     = tick.valid && push_ready;

    // Tick control shared by both lanes; decay on ticks where the masked loop count is zero.
    assign ctl.accept    = accept;
    assign ctl.disabled  = tick.robot_disabled;
    assign ctl.clear     = tick.first_enabled_tick;
    assign ctl.decay     = (tick.loop_count & mask_reg) == '0;
    assign ctl.threshold = thresh_reg;

    efm_lane u_left_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .drive       (tick.left_drive),
        .pulses_seen (tick.left_pulses_seen),
        .dir_reverse (tick.left_dir_reverse),
        .count       (left_count),
        .count_next  (lane_result.left_count)
    );

    efm_lane u_right_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .drive       (tick.right_drive),
        .pulses_seen (tick.right_pulses_seen),
        .dir_reverse (tick.right_dir_reverse),
        .count       (right_count),
        .count_next  (lane_result.right_count)
    );

    // Merge both lane counts into one result and hold it until transferred.
    efm_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .data       (lane_result),
        .push_ready (push_ready),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .res_data   (out_data)
    );

    assign result.left_fault_count  = out_data.left_count;
    assign result.right_fault_count = out_data.right_count;

    // A full skid means the output register holds an untaken result.
    `EFM_ASSERT_IMP(a_skid_implies_out, !tick.ready, result.valid,
        "skid full while output register empty")
    // Counters move only on a transferred tick.
    `EFM_ASSERT_NXT(a_hold_idle, !accept,
        $stable(left_count) && $stable(right_count), "counter changed without a tick")
    // A disabled tick leaves both counters alone.
    `EFM_ASSERT_NXT(a_hold_disabled, accept && tick.robot_disabled,
        $stable(left_count) && $stable(right_count), "disabled tick changed a counter")
    // The first enabled tick clears both counters.
    `EFM_ASSERT_NXT(a_clear_first, accept && !tick.robot_disabled
        && tick.first_enabled_tick, (left_count == '0) && (right_count == '0),
        "first enabled tick did not clear counters")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the encoder fault monitor: directed ticks, then random phases.
module tb_top;
    import efm_pkg::*;

    // One control-loop tick as the bench sees it.
    typedef struct {
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic                      left_pulses_seen;
        logic                      left_dir_reverse;
        logic                      right_pulses_seen;
        logic                      right_dir_reverse;
        logic                      robot_disabled;
        logic                      first_enabled_tick;
        logic [LOOP_W-1:0]         loop_count;
    } tick_t;

    // A tick on its way in; typed rows carry counts read off by hand.
    typedef struct {
        tick_t   t;
        bit      typed;
        result_t counts;
    } tick_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    efm_tick_if   tick ();
    efm_result_if result ();

    encoder_fault_monitor_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Predictor copy of the configuration and of both fault counters.
    logic [THRESH_W-1:0] threshold_now = THRESH_RESET;
    logic [MASK_W-1:0]   mask_now      = MASK_RESET;
    logic [COUNT_W-1:0]  left_faults_now  = '0;
    logic [COUNT_W-1:0]  right_faults_now = '0;

    tick_row_t ticks_in_flight[$];  // driven, not yet transferred
    result_t   counts_due[$];       // transferred, result still to come
    int        errors = 0;

    // Idle and stall knobs, in percent, plus the shape of the random ticks.
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        miss_pct       = 30;
    int        wrong_dir_pct  = 20;
    int        clear_pct      = 3;
    int        disabled_pct   = 10;
    logic [LOOP_W-1:0] loop_ctr = '0;

    // One wheel: bump the counter when the drive is strong but the encoder
    // shows no motion or motion the wrong way; hold at the ceiling.
    function automatic logic [COUNT_W-1:0] wheel_count(input logic [COUNT_W-1:0] faults,
                                                       input logic signed [DRIVE_W-1:0] drive,
                                                       input logic pulses,
                                                       input logic dir_rev);
        int magnitude;
        magnitude = (drive < 0) ? -int'(drive) : int'(drive);
        if (magnitude > int'(threshold_now) && (!pulses || drive[DRIVE_W-1] != dir_rev)
            && faults != FAULT_MAX)
            faults = faults + 1'b1;
        return faults;
    endfunction

    // Advance both counters by one tick and return what the block reports.
    function automatic result_t advance_counters(input tick_t t);
        logic [COUNT_W-1:0] lf;
        logic [COUNT_W-1:0] rf;
        result_t            r;
        if (!t.robot_disabled)
        begin
            lf = wheel_count(left_faults_now, t.left_drive, t.left_pulses_seen,
                             t.left_dir_reverse);
            rf = wheel_count(right_faults_now, t.right_drive, t.right_pulses_seen,
                             t.right_dir_reverse);
            // Clear wins over any increment; decay applies after the increment.
            if (t.first_enabled_tick)
            begin
                lf = '0;
                rf = '0;
            end
            else if ((t.loop_count & mask_now) == '0)
            begin
                if (lf != '0)
                    lf = lf - 1'b1;
                if (rf != '0)
                    rf = rf - 1'b1;
            end
            left_faults_now  = lf;
            right_faults_now = rf;
        end
        r.left_count  = left_faults_now;
        r.right_count = right_faults_now;
        return r;
    endfunction

    function automatic tick_t tick_of(input int ld, input int rd,
                                      input bit lp, input bit lr,
                                      input bit rp, input bit rr,
                                      input bit dis, input bit first,
                                      input int loop);
        tick_t t;
        t.left_drive         = ld[DRIVE_W-1:0];
        t.right_drive        = rd[DRIVE_W-1:0];
        t.left_pulses_seen   = lp;
        t.left_dir_reverse   = lr;
        t.right_pulses_seen  = rp;
        t.right_dir_reverse  = rr;
        t.robot_disabled     = dis;
        t.first_enabled_tick = first;
        t.loop_count         = loop[LOOP_W-1:0];
        return t;
    endfunction

    function automatic tick_row_t table_row(input tick_t t, input bit typed,
                                            input int l, input int r);
        tick_row_t row;
        row.t                  = t;
        row.typed              = typed;
        row.counts.left_count  = l[COUNT_W-1:0];
        row.counts.right_count = r[COUNT_W-1:0];
        return row;
    endfunction

    // Favor the extremes and the values right at the threshold.
    function automatic logic signed [DRIVE_W-1:0] pick_drive();
        logic [DRIVE_W-1:0] at_thr;
        at_thr = {1'b0, threshold_now};
        unique case ($urandom_range(9))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'h00;
            3: return at_thr;
            4: return at_thr + 8'd1;
            5: return -at_thr;
            6: return -(at_thr + 8'd1);
            default: return DRIVE_W'($urandom_range(255));
        endcase
    endfunction

    // Mostly a running loop counter and plausible encoder feedback, with noise.
    function automatic tick_t random_tick();
        tick_t t;
        t.left_drive         = pick_drive();
        t.right_drive        = pick_drive();
        t.left_pulses_seen   = ($urandom_range(99) >= miss_pct);
        t.left_dir_reverse   = t.left_drive[DRIVE_W-1] ^ ($urandom_range(99) < wrong_dir_pct);
        t.right_pulses_seen  = ($urandom_range(99) >= miss_pct);
        t.right_dir_reverse  = t.right_drive[DRIVE_W-1] ^ ($urandom_range(99) < wrong_dir_pct);
        t.robot_disabled     = ($urandom_range(99) < disabled_pct);
        t.first_enabled_tick = ($urandom_range(99) < clear_pct);
        if ($urandom_range(99) < 85)
        begin
            t.loop_count = loop_ctr;
            loop_ctr     = loop_ctr + 1'b1;
        end
        else
            t.loop_count = LOOP_W'($urandom_range(255));
        return t;
    endfunction

    // Drive one tick and hold it until the block takes it. Valid stays high
    // after the transfer so back-to-back ticks never drop it.
    task automatic send_tick(input tick_row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick.valid <= 1'b0;
            @(posedge clk);
        end
        ticks_in_flight.push_back(row);
        tick.valid              <= 1'b1;
        tick.left_drive         <= row.t.left_drive;
        tick.right_drive        <= row.t.right_drive;
        tick.left_pulses_seen   <= row.t.left_pulses_seen;
        tick.left_dir_reverse   <= row.t.left_dir_reverse;
        tick.right_pulses_seen  <= row.t.right_pulses_seen;
        tick.right_dir_reverse  <= row.t.right_dir_reverse;
        tick.robot_disabled     <= row.t.robot_disabled;
        tick.first_enabled_tick <= row.t.first_enabled_tick;
        tick.loop_count         <= row.t.loop_count;
        @(posedge clk);
        while (!tick.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every result has come back.
    task automatic wait_drained();
        tick.valid <= 1'b0;
        while (ticks_in_flight.size() != 0 || counts_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write the threshold register, then the decay mask register; only called while idle.
    task automatic set_config(input logic [CFG_DATA_W-1:0] thr_data,
                              input logic [CFG_DATA_W-1:0] mask_data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPEED_THRESHOLD;
        cfg_wdata <= thr_data;
        @(posedge clk);
        cfg_index <= CFG_DECAY_MASK;
        cfg_wdata <= mask_data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] thr_data,
                             input logic [CFG_DATA_W-1:0] mask_data,
                             input int idle, input int stall, input int count,
                             input int miss, input int wrong, input int clr, input int dis);
        int i;
        set_config(thr_data, mask_data);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        miss_pct       = miss;
        wrong_dir_pct  = wrong;
        clear_pct      = clr;
        disabled_pct   = dis;
        for (i = 0; i < count; i++)
            send_tick(table_row(random_tick(), 1'b0, 0, 0));
        wait_drained();
    endtask

    // Receiver: stall at the rate of the current phase.
    always @(posedge clk)
        result.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Track config writes, predict each transferred tick, then check each
    // transferred result against the oldest expectation. Predict first so
    // ordering holds even for a result in the same cycle.
    always @(posedge clk)
    begin : scoreboard
        tick_row_t row;
        result_t   predicted;
        result_t   want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SPEED_THRESHOLD: threshold_now = cfg_wdata[THRESH_W-1:0];
                    CFG_DECAY_MASK:      mask_now      = cfg_wdata[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (tick.valid && tick.ready)
            begin
                if (ticks_in_flight.size() == 0)
                begin
                    $error("tick transfer with no tick driven");
                    errors++;
                end
                else
                begin
                    row       = ticks_in_flight.pop_front();
                    predicted = advance_counters(row.t);
                    counts_due.push_back(row.typed ? row.counts : predicted);
                end
            end
            if (result.valid && result.ready)
            begin
                if (counts_due.size() == 0)
                begin
                    $error("result transfer with no tick outstanding");
                    errors++;
                end
                else
                begin
                    want = counts_due.pop_front();
                    if (result.left_fault_count !== want.left_count)
                    begin
                        $error("left_fault_count: expected %0d, got %0d",
                               want.left_count, result.left_fault_count);
                        errors++;
                    end
                    if (result.right_fault_count !== want.right_count)
                    begin
                        $error("right_fault_count: expected %0d, got %0d",
                               want.right_count, result.right_fault_count);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        tick_row_t directed[$];
        cfg_we                  <= 1'b0;
        cfg_index               <= CFG_SPEED_THRESHOLD;
        cfg_wdata               <= '0;
        tick.valid              <= 1'b0;
        tick.left_drive         <= '0;
        tick.right_drive        <= '0;
        tick.left_pulses_seen   <= 1'b0;
        tick.left_dir_reverse   <= 1'b0;
        tick.right_pulses_seen  <= 1'b0;
        tick.right_dir_reverse  <= 1'b0;
        tick.robot_disabled     <= 1'b0;
        tick.first_enabled_tick <= 1'b0;
        tick.loop_count         <= '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks at the reset configuration (threshold 30, mask 3).
        // Zero drive, no decay: counters stay at reset.
        directed.push_back(table_row(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, 0, 0));
        // Full reverse and full forward with no pulses: both count.
        directed.push_back(table_row(tick_of(-128, 127, 0, 0, 0, 0, 0, 0, 1), 1'b1, 1, 1));
        // Same drives, encoders agree: no change.
        directed.push_back(table_row(tick_of(-128, 127, 1, 1, 1, 0, 0, 0, 2), 1'b1, 1, 1));
        // Just above threshold, direction disagrees on both wheels.
        directed.push_back(table_row(tick_of(31, -31, 1, 1, 1, 0, 0, 0, 1), 1'b1, 2, 2));
        // Exactly at threshold: not a fault.
        directed.push_back(table_row(tick_of(30, -30, 0, 0, 0, 0, 0, 0, 1), 1'b1, 2, 2));
        // Disabled tick ignores clear, decay and faults.
        directed.push_back(table_row(tick_of(-128, -128, 0, 0, 0, 0, 1, 1, 0), 1'b1, 2, 2));
        // Increment and decay together on the left; decay only on the right.
        directed.push_back(table_row(tick_of(100, 0, 0, 0, 0, 0, 0, 0, 4), 1'b1, 2, 1));
        // Increment and clear together: clear wins.
        directed.push_back(table_row(tick_of(-100, -100, 0, 0, 0, 0, 0, 1, 5), 1'b1, 0, 0));
        // Decay with counters already at zero.
        directed.push_back(table_row(tick_of(0, 0, 1, 1, 1, 1, 0, 0, 0), 1'b1, 0, 0));
        // The rest go through the predictor.
        directed.push_back(table_row(tick_of(-1, 1, 0, 1, 0, 0, 0, 0, 3), 1'b0, 0, 0));
        directed.push_back(table_row(tick_of(127, -128, 0, 1, 0, 1, 0, 0, 255), 1'b0, 0, 0));
        directed.push_back(table_row(tick_of(-128, 127, 1, 0, 1, 1, 0, 0, 128), 1'b0, 0, 0));
        directed.push_back(table_row(tick_of(-128, -128, 0, 0, 0, 0, 1, 0, 255), 1'b0, 0, 0));
        directed.push_back(table_row(tick_of(31, 31, 1, 0, 1, 0, 0, 0, 1), 1'b0, 0, 0));
        directed.push_back(table_row(tick_of(-31, -31, 1, 1, 1, 1, 0, 0, 2), 1'b0, 0, 0));
        foreach (directed[i])
            send_tick(directed[i]);
        wait_drained();

        // Reset settings again, no idling on either side.
        run_phase({1'b1, THRESH_RESET}, MASK_RESET, 0, 0, 40, 30, 20, 3, 10);
        // Lowest threshold, rare decay, no pulses at all: drive the counters to saturation.
        run_phase({1'b0, 7'd0}, 8'hFF, 65, 0, 400, 100, 10, 0, 0);
        // Highest threshold, decay on every tick, receiver stalls.
        run_phase({1'b1, 7'd127}, 8'h00, 0, 65, 40, 40, 30, 5, 15);
        // Random settings, both sides idle.
        run_phase(CFG_DATA_W'($urandom_range(255)), CFG_DATA_W'($urandom_range(255)),
                  30, 30, 40, 30, 20, 3, 10);

        repeat (10) @(posedge clk);
        if (errors == 0 && counts_due.size() == 0 && ticks_in_flight.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[encoder_fault_monitor_top.f]
+incdir+design
design/efm_pkg.sv
design/efm_if.sv
design/efm_lane.sv
design/efm_merge.sv
design/encoder_fault_monitor_top.sv
bench/tb_top.sv
